>>> hw/rtl/twf_pkg.sv
`default_nettype none

package twf_pkg;

   localparam int STORE_AW    = 16;
   localparam int STORE_DEPTH = 65536;
   localparam int TEXEL_W     = 32;
   localparam int POS_W       = 16;
   localparam int SLOT_W      = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int MODE_W      = 2;

   localparam logic [SLOT_W-1:0] LAST_SLOT = 4'd15;
   localparam logic [CSR_DATA_W-1:0] SIZE_RESET = 9'd256;
   localparam logic [CSR_DATA_W-1:0] MIN_SIZE   = 9'd2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [MODE_W-1:0] WRAP_REPEAT = 2'd0;
   localparam logic [MODE_W-1:0] WRAP_MIRROR = 2'd1;
   localparam logic [MODE_W-1:0] WRAP_CLAMP  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_MODE_X  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_MODE_Y  = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_ISSUE
   } twf_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/texel_window_fetch_with_wrap.sv
// Texel window fetch with per-axis wrap.
// An item is taken at a rising edge with start high and busy low. A write item
// (req_cmd = 0) stores req_texel_data at req_texel_addr in the texel memory and
// produces no beat; another item can follow in the next cycle.
// A query item (req_cmd = 1) floors req_pos_x and req_pos_y and sends the 16
// texels of the 4x4 window around that point in row order, one beat per cycle,
// with rsp_last_sample on the final beat. The beats come from the coordinate
// stage and the memory read; busy stays high until the last read is issued, set
// by the single port of the texel memory, which serves one read per cycle.
// A query whose floored position lies outside the image gives one beat with
// rsp_out_of_range set, in the cycle after it is taken, and busy stays low.
// Each beat is valid for exactly one cycle with rsp_valid; the receiver cannot
// stall the block. The csr_ port writes image size and wrap modes at any edge
// with csr_write_en high; the user must use it only while the block is idle, as
// the block does not check this. Reset restores the registers to 256 by 256 with
// repeat on both axes, empties the pipeline; texels are undefined until written.
`default_nettype none

module texel_window_fetch_with_wrap
   import twf_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_cmd,
   input  wire logic [STORE_AW-1:0]        req_texel_addr,
   input  wire logic [TEXEL_W-1:0]         req_texel_data,
   input  wire logic signed [POS_W-1:0]    req_pos_x,
   input  wire logic signed [POS_W-1:0]    req_pos_y,
   output logic                            rsp_valid,
   output logic [TEXEL_W-1:0]              rsp_sample_value,
   output logic [SLOT_W-1:0]               rsp_window_slot,
   output logic                            rsp_last_sample,
   output logic                            rsp_out_of_range,
   input  wire logic                       csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_write_data
);

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int AW  = (WW > HW) ? WW : HW;
   localparam int CWD = AW + 2;
   localparam int PW  = POS_W + 1;
   localparam int MW  = 2 * AW + 1;
   localparam logic signed [CWD-1:0] ONE_S = 1;

   function automatic logic [AW-1:0] wrap_axis(input logic signed [CWD-1:0] c,
                                               input logic [AW-1:0] size,
                                               input logic [MODE_W-1:0] mode);
      logic signed [CWD-1:0] s;
      logic signed [CWD-1:0] r;
      s = signed'(CWD'(size));
      unique case (mode)
         WRAP_MIRROR: begin
            if (c[CWD-1]) begin
               r = ~c;
            end else if (c < s) begin
               r = c;
            end else begin
               r = s + s + ~c;
            end
         end
         WRAP_CLAMP: begin
            if (c[CWD-1]) begin
               r = '0;
            end else if (c > s - ONE_S) begin
               r = s - ONE_S;
            end else begin
               r = c;
            end
         end
         default: begin
            if (c[CWD-1]) begin
               r = c + s;
            end else if (c < s) begin
               r = c;
            end else begin
               r = c - s;
            end
         end
      endcase
      return r[AW-1:0];
   endfunction

   // Configuration registers.
   logic [CSR_DATA_W-1:0] image_width_ff;
   logic [CSR_DATA_W-1:0] image_height_ff;
   logic [MODE_W-1:0]     wrap_mode_x_ff;
   logic [MODE_W-1:0]     wrap_mode_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= SIZE_RESET;
         image_height_ff <= SIZE_RESET;
         wrap_mode_x_ff  <= WRAP_REPEAT;
         wrap_mode_y_ff  <= WRAP_REPEAT;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data;
            CSR_WRAP_MODE_X:  wrap_mode_x_ff  <= csr_write_data[MODE_W-1:0];
            CSR_WRAP_MODE_Y:  wrap_mode_y_ff  <= csr_write_data[MODE_W-1:0];
         endcase
      end
   end

   logic [AW-1:0] eff_w;
   logic [AW-1:0] eff_h;

   always_comb begin
      if (image_width_ff < MIN_SIZE) begin
         eff_w = AW'(MIN_SIZE);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         eff_w = AW'(MAX_WIDTH);
      end else begin
         eff_w = AW'(image_width_ff);
      end
      if (image_height_ff < MIN_SIZE) begin
         eff_h = AW'(MIN_SIZE);
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         eff_h = AW'(MAX_HEIGHT);
      end else begin
         eff_h = AW'(image_height_ff);
      end
   end

   // Acceptance and position check.
   logic                    accept;
   logic                    wr_accept;
   logic signed [POS_W-1:0] floor_x;
   logic signed [POS_W-1:0] floor_y;
   logic signed [PW-1:0]    floor_x_s;
   logic signed [PW-1:0]    floor_y_s;
   logic                    in_range;

   assign accept    = start && !busy;
   assign wr_accept = accept && (req_cmd == CMD_WRITE);
   assign floor_x   = req_pos_x >>> FRAC_BITS;
   assign floor_y   = req_pos_y >>> FRAC_BITS;
   assign floor_x_s = PW'(floor_x);
   assign floor_y_s = PW'(floor_y);
   assign in_range  = !floor_x[POS_W-1] && !floor_y[POS_W-1]
                      && (floor_x_s < signed'(PW'(eff_w)))
                      && (floor_y_s < signed'(PW'(eff_h)));

   // Sequencer.
   twf_state_type     state_ff, state_in;
   logic [SLOT_W-1:0] k_ff, k_in;
   logic [AW-1:0]     sx_ff, sx_in;
   logic [AW-1:0]     sy_ff, sy_in;
   logic              oor_vld_ff, oor_vld_in;

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      oor_vld_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_QUERY)) begin
               if (in_range) begin
                  state_in = ST_ISSUE;
                  k_in     = '0;
                  sx_in    = floor_x[AW-1:0];
                  sy_in    = floor_y[AW-1:0];
               end else begin
                  oor_vld_in = 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            k_in = k_ff + SLOT_W'(1);
            if (k_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         k_ff       <= '0;
         oor_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         k_ff       <= k_in;
         oor_vld_ff <= oor_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;
      sy_ff <= sy_in;
   end

   // Coordinate stage: window position to wrapped texel coordinates.
   logic signed [CWD-1:0] cx;
   logic signed [CWD-1:0] cy;
   logic                  c_vld_ff, c_vld_in;
   logic [AW-1:0]         xx_ff, xx_in;
   logic [AW-1:0]         yy_ff, yy_in;
   logic [SLOT_W-1:0]     c_slot_ff;

   assign cx       = signed'(CWD'(sx_ff)) - ONE_S + signed'(CWD'(k_ff[1:0]));
   assign cy       = signed'(CWD'(sy_ff)) - ONE_S + signed'(CWD'(k_ff[3:2]));
   assign c_vld_in = (state_ff == ST_ISSUE);
   assign xx_in    = wrap_axis(cx, eff_w, wrap_mode_x_ff);
   assign yy_in    = wrap_axis(cy, eff_h, wrap_mode_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= c_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      xx_ff     <= xx_in;
      yy_ff     <= yy_in;
      c_slot_ff <= k_ff;
   end

   // Address stage and texel memory.
   logic [MW-1:0]       lin_addr;
   logic [STORE_AW-1:0] ram_addr;
   logic [TEXEL_W-1:0]  ram_rdata;
   logic                rd_vld_ff;
   logic [SLOT_W-1:0]   rd_slot_ff;

   assign lin_addr = MW'(yy_ff) * MW'(eff_w) + MW'(xx_ff);
   assign ram_addr = wr_accept ? req_texel_addr : STORE_AW'(lin_addr);

   twf_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_texel_ram (
      .clock      (clock),
      .write_en   (wr_accept),
      .read_en    (c_vld_ff),
      .addr       (ram_addr),
      .write_data (req_texel_data),
      .read_data  (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff <= c_slot_ff;
   end

   // Result beat.
   assign busy             = (state_ff != ST_IDLE) || c_vld_ff;
   assign rsp_valid        = rd_vld_ff || oor_vld_ff;
   assign rsp_sample_value = oor_vld_ff ? '0 : ram_rdata;
   assign rsp_window_slot  = oor_vld_ff ? '0 : rd_slot_ff;
   assign rsp_last_sample  = oor_vld_ff || (rd_slot_ff == LAST_SLOT);
   assign rsp_out_of_range = oor_vld_ff;

endmodule

`default_nettype wire

>>> hw/rtl/twf_ram.sv
`default_nettype none

module twf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic                     read_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         write_data,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire
